>>> rtl/gnci_pkg.sv
// ----------------------------------------------------------------------------
// gnci_pkg
// shared constants, types and helpers for the grid neighbour cell index block
// ----------------------------------------------------------------------------
`default_nettype none

package gnci_pkg;

  localparam int MAX_GRID_DIM = 1024;
  localparam int CW           = $clog2(MAX_GRID_DIM);  // coordinate width
  localparam int SW           = CW + 1;                // effective size width
  localparam int PW           = 2 * CW + 1;            // plane size width
  localparam int YW           = 2 * CW;                // decoded y width
  localparam int IW           = 30;                    // linear index width
  localparam int FW           = 10;                    // input coordinate field width
  localparam int CFG_W        = 11;
  localparam int CFG_IW       = 2;
  localparam int RESET_SIZE   = 16;
  localparam int NOFS         = 27;                    // 3 x 3 x 3 offsets
  localparam int CENTRE       = 13;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  localparam logic OP_INDEX = 1'b0;
  localparam logic OP_COORD = 1'b1;

  localparam logic [CFG_IW-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic [CW-1:0] cx;
    logic [YW-1:0] cy;
    logic [IW-1:0] cz;
  } cell_t;

  typedef struct packed {
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [SW-1:0] sz;
    logic [PW-1:0] plane;
  } grid_t;

  typedef struct packed {
    logic  vld;
    cell_t loc;
  } qpush_t;

  function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) begin
      r = SW'(1);
    end else if (int'(v) > MAX_GRID_DIM) begin
      r = SW'(MAX_GRID_DIM);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gnci_front.sv
// ----------------------------------------------------------------------------
// gnci_front
// accepts items, decodes linear indices with a bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module gnci_front
  import gnci_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_operation,
  input  wire logic [IW-1:0] in_cell_index,
  input  wire logic [FW-1:0] in_coord_x,
  input  wire logic [FW-1:0] in_coord_y,
  input  wire logic [FW-1:0] in_coord_z,
  input  wire grid_t         grid,
  input  wire logic          q_full,
  output qpush_t             qpush
);

  localparam int CNT_W = $clog2(IW + 1);

  typedef enum logic [1:0] {F_IDLE, F_DIV_Z, F_DIV_Y, F_DONE} fstate_t;

  fstate_t          state_r;
  logic             res_vld_r;
  cell_t            res_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IW-1:0]    num_r;
  logic [PW-1:0]    rem_r;
  logic [IW-1:0]    quo_r;
  logic [PW-1:0]    dsr_r;
  logic [IW-1:0]    cz_r;

  logic             res_free;
  logic             res_load;
  logic             accept;
  logic [PW:0]      trial;
  logic             ge;
  logic [PW:0]      diff;
  logic [PW-1:0]    rem_step;
  logic [IW-1:0]    quo_step;
  logic             last_step;

  assign res_free = !res_vld_r || !q_full;
  assign in_stall = (state_r != F_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;
  assign res_load = (accept && (in_operation == OP_COORD)) ||
                    ((state_r == F_DONE) && res_free);

  // one restoring division step per cycle
  assign trial     = {rem_r, num_r[IW-1]};
  assign ge        = trial >= {1'b0, dsr_r};
  assign diff      = trial - {1'b0, dsr_r};
  assign rem_step  = ge ? diff[PW-1:0] : trial[PW-1:0];
  assign quo_step  = {quo_r[IW-2:0], ge};
  assign last_step = cnt_r == CNT_W'(1);

  assign qpush.vld = res_vld_r;
  assign qpush.loc = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_load || (res_vld_r && q_full);
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            if (in_operation == OP_COORD) begin
              res_r.cx <= CW'(in_coord_x);
              res_r.cy <= YW'(in_coord_y);
              res_r.cz <= IW'(in_coord_z);
            end else begin
              state_r <= F_DIV_Z;
              num_r   <= in_cell_index;
              rem_r   <= '0;
              quo_r   <= '0;
              dsr_r   <= grid.plane;
              cnt_r   <= CNT_W'(IW);
            end
          end
        end
        F_DIV_Z: begin
          if (last_step) begin
            state_r <= F_DIV_Y;
            cz_r    <= quo_step;
            num_r   <= {rem_step[YW-1:0], {(IW-YW){1'b0}}};
            rem_r   <= '0;
            quo_r   <= '0;
            dsr_r   <= PW'(grid.sx);
            cnt_r   <= CNT_W'(YW);
          end else begin
            num_r <= {num_r[IW-2:0], 1'b0};
            rem_r <= rem_step;
            quo_r <= quo_step;
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        F_DIV_Y: begin
          num_r <= {num_r[IW-2:0], 1'b0};
          rem_r <= rem_step;
          quo_r <= quo_step;
          cnt_r <= cnt_r - CNT_W'(1);
          if (last_step) begin
            state_r <= F_DONE;
          end
        end
        F_DONE: begin
          if (res_free) begin
            res_r.cx <= rem_r[CW-1:0];
            res_r.cy <= quo_r[YW-1:0];
            res_r.cz <= cz_r;
            state_r  <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/gnci_queue.sv
// ----------------------------------------------------------------------------
// gnci_queue
// short queue of decoded cells between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gnci_queue
  import gnci_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qpush_t qpush,
  output logic        q_full,
  input  wire logic   q_pop,
  output logic        q_vld,
  output cell_t       q_cell
);

  cell_t           mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QAW:0]    count_r;
  logic            do_push;
  logic            do_pop;

  assign q_full  = count_r == (QAW+1)'(QDEPTH);
  assign q_vld   = count_r != '0;
  assign q_cell  = mem[rd_ptr_r];
  assign do_push = qpush.vld && !q_full;
  assign do_pop  = q_pop && q_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= qpush.loc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/gnci_back.sv
// ----------------------------------------------------------------------------
// gnci_back
// walks the in-bounds neighbour mask, one linear index per unstalled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gnci_back
  import gnci_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire grid_t         grid,
  input  wire logic          q_vld,
  input  wire cell_t         q_cell,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [IW-1:0]      out_neighbour_index,
  output logic               out_last,
  output logic               out_empty_res
);

  logic                a_vld_r;
  logic                a_empty_r;
  logic [NOFS-1:0]     a_mask_r;
  logic [CW-1:0]       a_cx_r;
  logic [CW-1:0]       a_cy_r;
  logic [CW-1:0]       a_cz_r;

  logic                b_vld_r;
  logic                b_last_r;
  logic                b_empty_r;
  logic [CW-1:0]       b_nx_r;
  logic [CW-1:0]       b_ny_r;
  logic [CW-1:0]       b_nz_r;

  logic                c_vld_r;
  logic                c_last_r;
  logic                c_empty_r;
  logic [CW-1:0]       c_nx_r;
  logic [IW-1:0]       c_py_r;
  logic [IW-1:0]       c_pz_r;

  logic                out_vld_r;
  logic [IW-1:0]       out_index_r;
  logic                out_last_r;
  logic                out_empty_r;

  logic                adv;
  logic [2:0]          vx;
  logic [2:0]          vy;
  logic [2:0]          vz;
  logic [NOFS-1:0]     load_mask;
  logic [NOFS-1:0]     onehot;
  logic [NOFS-1:0]     mask_rest;
  logic [2:0]          sel_x;
  logic [2:0]          sel_y;
  logic [2:0]          sel_z;
  logic [CW-1:0]       nx;
  logic [CW-1:0]       ny;
  logic [CW-1:0]       nz;
  logic [CW+SW-1:0]    py_prod;
  logic [CW+PW-1:0]    pz_prod;

  assign adv   = !out_vld_r || !out_stall;
  assign q_pop = q_vld && !a_vld_r;

  // bounds of the three offsets on each axis
  always_comb begin
    vx[0] = (q_cell.cx != '0) && (SW'(q_cell.cx) <= grid.sx);
    vx[1] = SW'(q_cell.cx) < grid.sx;
    vx[2] = (SW'(q_cell.cx) + SW'(1)) < grid.sx;
    vy[0] = (q_cell.cy != '0) && ((YW+1)'(q_cell.cy) <= (YW+1)'(grid.sy));
    vy[1] = (YW+1)'(q_cell.cy) < (YW+1)'(grid.sy);
    vy[2] = ((YW+1)'(q_cell.cy) + (YW+1)'(1)) < (YW+1)'(grid.sy);
    vz[0] = (q_cell.cz != '0) && ((IW+1)'(q_cell.cz) <= (IW+1)'(grid.sz));
    vz[1] = (IW+1)'(q_cell.cz) < (IW+1)'(grid.sz);
    vz[2] = ((IW+1)'(q_cell.cz) + (IW+1)'(1)) < (IW+1)'(grid.sz);
    for (int k = 0; k < NOFS; k++) begin
      load_mask[k] = vx[k / 9] & vy[(k / 3) % 3] & vz[k % 3];
    end
    load_mask[CENTRE] = 1'b0;
  end

  // lowest remaining offset, x outermost and z innermost
  always_comb begin
    onehot    = a_mask_r & (~a_mask_r + NOFS'(1));
    mask_rest = a_mask_r & ~onehot;
    sel_x     = '0;
    sel_y     = '0;
    sel_z     = '0;
    for (int k = 0; k < NOFS; k++) begin
      sel_x[k / 9]       = sel_x[k / 9] | onehot[k];
      sel_y[(k / 3) % 3] = sel_y[(k / 3) % 3] | onehot[k];
      sel_z[k % 3]       = sel_z[k % 3] | onehot[k];
    end
    nx = sel_x[0] ? a_cx_r - CW'(1) : (sel_x[2] ? a_cx_r + CW'(1) : a_cx_r);
    ny = sel_y[0] ? a_cy_r - CW'(1) : (sel_y[2] ? a_cy_r + CW'(1) : a_cy_r);
    nz = sel_z[0] ? a_cz_r - CW'(1) : (sel_z[2] ? a_cz_r + CW'(1) : a_cz_r);
  end

  assign py_prod = b_ny_r * grid.sx;
  assign pz_prod = b_nz_r * grid.plane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!a_vld_r) begin
        if (q_vld) begin
          a_vld_r   <= 1'b1;
          a_empty_r <= load_mask == '0;
          a_mask_r  <= load_mask;
          a_cx_r    <= q_cell.cx;
          a_cy_r    <= q_cell.cy[CW-1:0];
          a_cz_r    <= q_cell.cz[CW-1:0];
        end
      end else if (adv) begin
        if (a_empty_r) begin
          a_vld_r <= 1'b0;
        end else begin
          a_vld_r  <= mask_rest != '0;
          a_mask_r <= mask_rest;
        end
      end

      if (adv) begin
        b_vld_r   <= a_vld_r;
        b_empty_r <= a_empty_r;
        b_last_r  <= a_empty_r || (mask_rest == '0);
        b_nx_r    <= a_empty_r ? '0 : nx;
        b_ny_r    <= a_empty_r ? '0 : ny;
        b_nz_r    <= a_empty_r ? '0 : nz;

        c_vld_r   <= b_vld_r;
        c_last_r  <= b_last_r;
        c_empty_r <= b_empty_r;
        c_nx_r    <= b_nx_r;
        c_py_r    <= IW'(py_prod);
        c_pz_r    <= pz_prod[IW-1:0];

        out_vld_r   <= c_vld_r;
        out_last_r  <= c_last_r;
        out_empty_r <= c_empty_r;
        out_index_r <= IW'(c_nx_r) + c_py_r + c_pz_r;
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_neighbour_index = out_index_r;
  assign out_last            = out_last_r;
  assign out_empty_res       = out_empty_r;

endmodule

`default_nettype wire

>>> rtl/grid_neighbour_cell_index.sv
// ----------------------------------------------------------------------------
// grid_neighbour_cell_index
// lists the in-bounds 26-neighbourhood of one cell of a configurable 3d grid
// ----------------------------------------------------------------------------
// items arrive on the in_ channel as a linear index or as x, y, z coordinates;
// the grid size comes from three registers written through cfg_we, cfg_index
// and cfg_data, which reset to 16 x 16 x 16 and saturate to 1..1024.
// each item gives 1 to 26 results on the out_ channel, one per unstalled
// cycle, in x-outer, z-inner offset order; out_last marks the final one and a
// cell with no neighbour gives a single result with out_empty_res set.
// the front takes a coordinate item each cycle while the queue has room; a
// linear index goes through a bit-serial divider, 30 steps for z and 20 for y,
// so the front stays busy until the decoded cell enters its result register.
// the back emits one result per cycle while out_stall is low; it loads each
// item into stage a before its first result, and a result passes through the
// b and c registers into the output register.
// a four-entry queue decouples front and back. out_stall freezes the back
// pipeline with every result held; in_stall rises once the queue and the
// front result register are full or the divider is busy.
// reset (rst_n low, synchronous) empties the queue and pipeline and restores
// the size registers.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbour_cell_index
  import gnci_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_operation,
  input  wire logic [IW-1:0]     in_cell_index,
  input  wire logic [FW-1:0]     in_coord_x,
  input  wire logic [FW-1:0]     in_coord_y,
  input  wire logic [FW-1:0]     in_coord_z,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IW-1:0]          out_neighbour_index,
  output logic                   out_last,
  output logic                   out_empty_res
);

  logic [SW-1:0]   sx_r;
  logic [SW-1:0]   sy_r;
  logic [SW-1:0]   sz_r;
  logic [PW-1:0]   plane_r;
  logic [SW-1:0]   wr_size;
  logic [2*SW-1:0] plane_x;
  logic [2*SW-1:0] plane_y;
  grid_t           grid;
  qpush_t          qpush;
  logic            q_full;
  logic            q_pop;
  logic            q_vld;
  cell_t           q_cell;

  assign wr_size = eff_size(cfg_data);
  assign plane_x = wr_size * sy_r;
  assign plane_y = sx_r * wr_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= SW'(RESET_SIZE);
      sy_r    <= SW'(RESET_SIZE);
      sz_r    <= SW'(RESET_SIZE);
      plane_r <= PW'(RESET_SIZE * RESET_SIZE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: begin
          sx_r    <= wr_size;
          plane_r <= plane_x[PW-1:0];
        end
        REG_SIZE_Y: begin
          sy_r    <= wr_size;
          plane_r <= plane_y[PW-1:0];
        end
        REG_SIZE_Z: sz_r <= wr_size;
        default: ;
      endcase
    end
  end

  assign grid.sx    = sx_r;
  assign grid.sy    = sy_r;
  assign grid.sz    = sz_r;
  assign grid.plane = plane_r;

  gnci_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_cell_index (in_cell_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .grid          (grid),
    .q_full        (q_full),
    .qpush         (qpush)
  );

  gnci_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .qpush  (qpush),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_vld  (q_vld),
    .q_cell (q_cell)
  );

  gnci_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .grid                (grid),
    .q_vld               (q_vld),
    .q_cell              (q_cell),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_index (out_neighbour_index),
    .out_last            (out_last),
    .out_empty_res       (out_empty_res)
  );

endmodule

`default_nettype wire

>>> bench/neighbour_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_checker
// watches the cfg_, in_ and out_ ports of the grid neighbour block, keeps its
// own copy of the grid size, lists the expected neighbour indices of every
// accepted item and compares each accepted result against the oldest one
// ----------------------------------------------------------------------------
module neighbour_checker
  import gnci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_operation,
  input  logic [IW-1:0]     in_cell_index,
  input  logic [FW-1:0]     in_coord_x,
  input  logic [FW-1:0]     in_coord_y,
  input  logic [FW-1:0]     in_coord_z,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [IW-1:0]     out_neighbour_index,
  input  logic              out_last,
  input  logic              out_empty_res,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [IW-1:0] index;
    logic          last;
    logic          empty;
  } neighbour_t;

  neighbour_t       expected_neighbours[$];
  logic [CFG_W-1:0] grid_reg[3];
  int               fail_count;

  function automatic longint clamp_size(logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > MAX_GRID_DIM) begin
      return MAX_GRID_DIM;
    end
    return longint'(v);
  endfunction

  function automatic void enumerate_neighbours(logic op, logic [IW-1:0] idx,
                                               logic [FW-1:0] x, logic [FW-1:0] y,
                                               logic [FW-1:0] z);
    longint     sx, sy, sz, plane, rem, cx, cy, cz, nx, ny, nz;
    neighbour_t nb;
    neighbour_t found[$];
    sx    = clamp_size(grid_reg[REG_SIZE_X]);
    sy    = clamp_size(grid_reg[REG_SIZE_Y]);
    sz    = clamp_size(grid_reg[REG_SIZE_Z]);
    plane = sx * sy;
    if (op == OP_INDEX) begin
      cz  = longint'(idx) / plane;
      rem = longint'(idx) - cz * plane;
      cy  = rem / sx;
      cx  = rem - cy * sx;
    end else begin
      cx = longint'(x);
      cy = longint'(y);
      cz = longint'(z);
    end
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        for (int dk = -1; dk <= 1; dk++) begin
          nx = cx + di;
          ny = cy + dj;
          nz = cz + dk;
          if (nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz &&
              !(di == 0 && dj == 0 && dk == 0)) begin
            nb.index = IW'(nx + ny * sx + nz * plane);
            nb.last  = 1'b0;
            nb.empty = 1'b0;
            found = {found, nb};
          end
        end
      end
    end
    if (found.size() == 0) begin
      nb.index = '0;
      nb.last  = 1'b1;
      nb.empty = 1'b1;
      found = {found, nb};
    end else begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[i]) begin
      expected_neighbours = {expected_neighbours, found[i]};
    end
  endfunction

  function automatic void note_mismatch(logic have_want, neighbour_t want, neighbour_t got);
    if (fail_count < 10) begin
      if (have_want) begin
        $display("mismatch: expected %0d last %0b empty %0b, got %0d last %0b empty %0b",
                 want.index, want.last, want.empty, got.index, got.last, got.empty);
      end else begin
        $display("mismatch: unexpected result index %0d last %0b empty %0b",
                 got.index, got.last, got.empty);
      end
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin
    neighbour_t got;
    neighbour_t want;
    if (!rst_n) begin
      grid_reg[REG_SIZE_X] = CFG_W'(RESET_SIZE);
      grid_reg[REG_SIZE_Y] = CFG_W'(RESET_SIZE);
      grid_reg[REG_SIZE_Z] = CFG_W'(RESET_SIZE);
      expected_neighbours.delete();
      fail_count = 0;
    end else begin
      if (cfg_we && cfg_index <= REG_SIZE_Z) begin
        grid_reg[cfg_index] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        enumerate_neighbours(in_operation, in_cell_index, in_coord_x, in_coord_y, in_coord_z);
      end
      if (out_valid && !out_stall) begin
        got.index = out_neighbour_index;
        got.last  = out_last;
        got.empty = out_empty_res;
        if (expected_neighbours.size() == 0) begin
          want = '0;
          note_mismatch(1'b0, want, got);
        end else begin
          want = expected_neighbours.pop_front();
          if (got !== want) begin
            note_mismatch(1'b1, want, got);
          end
        end
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_neighbours.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the grid neighbour block through a set of grid sizes: directed cells
// at corners, edges and outside the grid, then random bursts of index and
// coordinate items with random receiver stalls and one long hold-off
// ----------------------------------------------------------------------------
module testbench;
  import gnci_pkg::*;

  localparam int LIMIT        = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_SETS  = 9;
  localparam int ITEMS_PER_SET = 32;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [IW-1:0]     in_cell_index;
  logic [FW-1:0]     in_coord_x;
  logic [FW-1:0]     in_coord_y;
  logic [FW-1:0]     in_coord_z;
  logic              out_valid;
  logic              out_stall;
  logic [IW-1:0]     out_neighbour_index;
  logic              out_last;
  logic              out_empty_res;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;
  int unsigned ext_x, ext_y, ext_z;

  grid_neighbour_cell_index DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_cell_index       (in_cell_index),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_index (out_neighbour_index),
    .out_last            (out_last),
    .out_empty_res       (out_empty_res)
  );

  neighbour_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_cell_index       (in_cell_index),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_index (out_neighbour_index),
    .out_last            (out_last),
    .out_empty_res       (out_empty_res),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall segments, long hold-off on request
  initial begin
    int hold_left;
    int seg_left;
    int mode;
    hold_left = 0;
    seg_left  = 0;
    mode      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic offer_item(logic op, logic [IW-1:0] idx, logic [FW-1:0] x,
                            logic [FW-1:0] y, logic [FW-1:0] z);
    int gap;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_cell_index <= idx;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_coord(logic [FW-1:0] x, logic [FW-1:0] y, logic [FW-1:0] z);
    offer_item(OP_COORD, IW'($urandom), x, y, z);
  endtask

  task automatic send_index(logic [IW-1:0] idx);
    offer_item(OP_INDEX, idx, FW'($urandom), FW'($urandom), FW'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding != 0);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] z);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIZE_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data  <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (4) @(posedge clk);
    ext_x = (x == '0) ? 1 : (x > MAX_GRID_DIM) ? MAX_GRID_DIM : x;
    ext_y = (y == '0) ? 1 : (y > MAX_GRID_DIM) ? MAX_GRID_DIM : y;
    ext_z = (z == '0) ? 1 : (z > MAX_GRID_DIM) ? MAX_GRID_DIM : z;
  endtask

  function automatic logic [CFG_W-1:0] random_size();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(1);
      1:       return '0;
      2:       return CFG_W'($urandom_range(MAX_GRID_DIM + 1, 2047));
      3:       return CFG_W'(MAX_GRID_DIM);
      4, 5:    return CFG_W'($urandom_range(2, 4));
      6:       return CFG_W'($urandom_range(41, MAX_GRID_DIM));
      default: return CFG_W'($urandom_range(5, 40));
    endcase
  endfunction

  // mostly inside the grid, sometimes on or past the border
  function automatic logic [FW-1:0] pick_coord(int unsigned extent);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FW'(extent - 1);
      2:       return FW'(extent);
      3:       return FW'($urandom);
      default: return FW'($urandom_range(0, extent - 1));
    endcase
  endfunction

  task automatic random_item();
    int unsigned cells;
    cells = ext_x * ext_y * ext_z;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 4) != 0) begin
        send_index(IW'($urandom_range(0, cells - 1)));
      end else begin
        send_index(IW'($urandom));
      end
    end else begin
      send_coord(pick_coord(ext_x), pick_coord(ext_y), pick_coord(ext_z));
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SIZE_X;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_operation  <= OP_INDEX;
    in_cell_index <= '0;
    in_coord_x    <= '0;
    in_coord_y    <= '0;
    in_coord_z    <= '0;
    ext_x = RESET_SIZE;
    ext_y = RESET_SIZE;
    ext_z = RESET_SIZE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid 16 x 16 x 16
    send_coord(10'd0, 10'd0, 10'd0);
    send_coord(10'd15, 10'd15, 10'd15);
    send_coord(10'd7, 10'd8, 10'd9);
    send_coord(10'd15, 10'd0, 10'd8);
    send_coord(10'd16, 10'd0, 10'd0);
    send_coord(10'd1023, 10'd1023, 10'd1023);
    send_index(30'd0);
    send_index(30'd1234);
    send_index(30'd4095);
    send_index(30'd4096);
    send_index(30'h3fff_ffff);

    // single-cell grid, written as 1 and as 0
    set_grid(11'd1, 11'd1, 11'd1);
    send_coord(10'd0, 10'd0, 10'd0);
    send_index(30'd0);
    send_coord(10'd1, 10'd0, 10'd0);
    set_grid(11'd0, 11'd0, 11'd0);
    send_coord(10'd0, 10'd0, 10'd0);
    send_index(30'd5);

    // oversized registers saturate to the full grid
    set_grid(11'd2047, 11'd2047, 11'd2047);
    send_coord(10'd1023, 10'd1023, 10'd1023);
    send_coord(10'd0, 10'd0, 10'd0);
    send_coord(10'd512, 10'd1, 10'd1022);
    send_index(30'h3fff_ffff);
    send_index(30'd0);
    send_index(30'h2aaa_5555);

    // long thin grid
    set_grid(11'd1024, 11'd1, 11'd2);
    send_index(30'd1500);
    send_coord(10'd1023, 10'd0, 10'd1);

    for (int s = 0; s < RANDOM_SETS; s++) begin
      set_grid(random_size(), random_size(), random_size());
      if (s == 0) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        random_item();
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
